// ----- hdl/bmr_pkg.sv -----
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types and constants of the bit matrix row engine.
// ----------------------------------------------------------------------------
package bmr_pkg;

	// fixed field widths
	localparam int OPCODE_W = 3;
	localparam int ROW_W    = 8;
	localparam int COL_W    = 8;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 1;

	// default sizes
	localparam int MAX_ROWS_DEF      = 256;
	localparam int MAX_COLUMNS_DEF   = 256;
	localparam int WORD_BITS_DEF     = 64;
	localparam int WORDS_PER_ROW_DEF = 4;

	typedef enum logic [OPCODE_W-1:0] {
		OP_GET_BIT    = 3'd0,
		OP_SET_BIT    = 3'd1,
		OP_COPY_ROW   = 3'd2,
		OP_AND_ROW    = 3'd3,
		OP_OR_ROW     = 3'd4,
		OP_TEST_ONES  = 3'd5,
		OP_TEST_ZEROS = 3'd6
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_COLUMNS = 1'd0,
		REG_ACTIVE_ROWS    = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_APPLY,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;  // write zero at sweep address, advance sweep
		logic load;   // latch item, check ranges, restart word loop
		logic rd;     // read current word of source and target rows
		logic apply;  // use read data, write back, read next word
		logic post;   // move result into output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic word_last;
	} ctl_sts_t;

endpackage

// ----- hdl/bmr_ifs.sv -----
// ----------------------------------------------------------------------------
// bmr_req_if / bmr_rsp_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface bmr_req_if;
	logic                         valid;
	logic                         ready;
	logic [bmr_pkg::OPCODE_W-1:0] opcode;
	logic [bmr_pkg::ROW_W-1:0]    target_row;
	logic [bmr_pkg::ROW_W-1:0]    source_row;
	logic [bmr_pkg::COL_W-1:0]    column;
	logic                         bit_value;

	modport source (output valid, opcode, target_row, source_row, column, bit_value,
		input ready);
	modport sink (input valid, opcode, target_row, source_row, column, bit_value,
		output ready);
endinterface

interface bmr_rsp_if;
	logic valid;
	logic ready;
	logic bit_result;
	logic range_error;

	modport source (output valid, bit_result, range_error, input ready);
	modport sink (input valid, bit_result, range_error, output ready);
endinterface

// ----- hdl/bmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmr_ctrl
// Sequencer: clearing sweep, word loop per item and the output handshake.
// ----------------------------------------------------------------------------
module bmr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bmr_pkg::ctl_cmd_t cmd,
	input  bmr_pkg::ctl_sts_t sts
);

	bmr_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            post;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmr_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (post)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmr_pkg::ST_CLEAR: begin
				if (sts.clr_last)
					state_d = bmr_pkg::ST_IDLE;
			end
			bmr_pkg::ST_IDLE: begin
				if (req_valid)
					state_d = bmr_pkg::ST_READ;
			end
			bmr_pkg::ST_READ: begin
				state_d = bmr_pkg::ST_APPLY;
			end
			bmr_pkg::ST_APPLY: begin
				if (sts.word_last)
					state_d = bmr_pkg::ST_DONE;
			end
			bmr_pkg::ST_DONE: begin
				if (!out_valid_q || rsp_ready)
					state_d = bmr_pkg::ST_IDLE;
			end
			default: begin
				state_d = bmr_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		post      = 1'b0;
		case (state_q)
			bmr_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			bmr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			bmr_pkg::ST_READ: begin
				cmd.rd = 1'b1;
			end
			bmr_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
			end
			bmr_pkg::ST_DONE: begin
				post = !out_valid_q || rsp_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
		cmd.post = post;
	end

	assign rsp_valid = out_valid_q;

endmodule

// ----- hdl/bmr_dp.sv -----
// ----------------------------------------------------------------------------
// bmr_dp
// Datapath: row store, configuration, item registers, word loop, result.
// ----------------------------------------------------------------------------
module bmr_dp #(
	parameter int MAX_ROWS      = bmr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS   = bmr_pkg::MAX_COLUMNS_DEF,
	parameter int WORD_BITS     = bmr_pkg::WORD_BITS_DEF,
	parameter int WORDS_PER_ROW = bmr_pkg::WORDS_PER_ROW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bmr_pkg::ctl_cmd_t             cmd,
	output bmr_pkg::ctl_sts_t             sts,
	input  logic [bmr_pkg::OPCODE_W-1:0]  opcode,
	input  logic [bmr_pkg::ROW_W-1:0]     target_row,
	input  logic [bmr_pkg::ROW_W-1:0]     source_row,
	input  logic [bmr_pkg::COL_W-1:0]     column,
	input  logic                          bit_value,
	input  logic                          cfg_wr_en,
	input  logic [bmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmr_pkg::CFG_W-1:0]     cfg_data,
	output logic                          bit_result,
	output logic                          range_error
);

	localparam int DEPTH    = MAX_ROWS * WORDS_PER_ROW;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_BITS = WORDS_PER_ROW * WORD_BITS;
	localparam int COL_CAP  = (ROW_BITS < MAX_COLUMNS) ? ROW_BITS : MAX_COLUMNS;
	localparam int BW0      = $clog2(ROW_BITS + 1);
	localparam int CW       = (BW0 > bmr_pkg::CFG_W) ? BW0 : bmr_pkg::CFG_W;
	localparam int CW1      = CW + 1;
	localparam int RW0      = $clog2(MAX_ROWS + 1);
	localparam int RW       = (RW0 > bmr_pkg::CFG_W) ? RW0 : bmr_pkg::CFG_W;
	localparam int WIW      = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
	localparam int SW       = $clog2(WORD_BITS);

	localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] src_word_q, tgt_word_q;

	logic [CW-1:0]  act_cols_q;
	logic [RW-1:0]  act_rows_q;
	logic [AW-1:0]  clr_q;
	logic [WIW-1:0] word_q;
	logic [CW-1:0]  base_q;

	logic [bmr_pkg::OPCODE_W-1:0] op_q;
	logic [bmr_pkg::ROW_W-1:0]    tgt_q, src_q;
	logic [bmr_pkg::COL_W-1:0]    col_q;
	logic                         val_q;
	logic                         err_q;
	logic                         acc_q;

	logic [bmr_pkg::CFG_W-1:0] cfg_v;
	logic                      load_err;
	logic [WIW-1:0]            rd_word;
	logic [AW-1:0]             rd_src_addr, rd_tgt_addr, wr_addr;
	logic                      wr_en;
	logic [WORD_BITS-1:0]      wr_data;
	logic [CW1-1:0]            base_end;
	logic                      hit;
	logic [SW-1:0]             sh;
	logic [WORD_BITS-1:0]      bit_sel;
	logic [WORD_BITS-1:0]      test_mask;
	logic                      test_ok;
	logic                      acc_d;

	// configuration, saturated into range
	always_comb begin
		cfg_v = (cfg_data == '0) ? bmr_pkg::CFG_W'(1) : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cols_q <= CW'(COL_CAP);
			act_rows_q <= RW'(MAX_ROWS);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bmr_pkg::REG_ACTIVE_COLUMNS: begin
					act_cols_q <= (CW'(cfg_v) > CW'(COL_CAP)) ? CW'(COL_CAP) : CW'(cfg_v);
				end
				bmr_pkg::REG_ACTIVE_ROWS: begin
					act_rows_q <= (RW'(cfg_v) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg_v);
				end
				default: begin
					act_rows_q <= act_rows_q;
				end
			endcase
		end
	end

	// operand range check at accept
	always_comb begin
		load_err = 1'b0;
		if (opcode inside {bmr_pkg::OP_GET_BIT, bmr_pkg::OP_SET_BIT})
			load_err = (CW'(column) >= act_cols_q) || (RW'(target_row) >= act_rows_q);
		else if (opcode inside {bmr_pkg::OP_COPY_ROW, bmr_pkg::OP_AND_ROW,
				bmr_pkg::OP_OR_ROW})
			load_err = (RW'(target_row) >= act_rows_q) || (RW'(source_row) >= act_rows_q);
		else if (opcode inside {bmr_pkg::OP_TEST_ONES, bmr_pkg::OP_TEST_ZEROS})
			load_err = RW'(target_row) >= act_rows_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			tgt_q <= target_row;
			src_q <= source_row;
			col_q <= column;
			val_q <= bit_value;
			err_q <= load_err;
		end
	end

	// word loop counters and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			word_q <= '0;
			base_q <= '0;
			acc_q  <= 1'b0;
		end else begin
			if (cmd.clear)
				clr_q <= clr_q + AW'(1);
			if (cmd.load) begin
				word_q <= '0;
				base_q <= '0;
				acc_q  <= 1'b1;
			end else if (cmd.apply) begin
				word_q <= word_q + WIW'(1);
				base_q <= base_q + CW'(WORD_BITS);
				acc_q  <= acc_d;
			end
		end
	end

	assign sts.clr_last  = clr_q == AW'(DEPTH - 1);
	assign sts.word_last = word_q == WIW'(WORDS_PER_ROW - 1);

	// apply reads the next word while the current one is written back
	assign rd_word     = cmd.apply ? word_q + WIW'(1) : word_q;
	assign rd_src_addr = AW'(32'(src_q) * WORDS_PER_ROW + 32'(rd_word));
	assign rd_tgt_addr = AW'(32'(tgt_q) * WORDS_PER_ROW + 32'(rd_word));

	// column position inside the current word
	always_comb begin
		base_end = CW1'(base_q) + CW1'(WORD_BITS);
		hit      = (CW1'(col_q) >= CW1'(base_q)) && (CW1'(col_q) < base_end);
		sh       = SW'(CW'(col_q) - base_q);
		bit_sel  = WORD_BITS'(1) << sh;
		if (CW1'(act_cols_q) >= base_end)
			test_mask = FULL_WORD;
		else if (act_cols_q <= base_q)
			test_mask = '0;
		else
			test_mask = ~(FULL_WORD << SW'(act_cols_q - base_q));
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = tgt_word_q;
		acc_d   = acc_q;
		test_ok = 1'b0;
		case (op_q)
			bmr_pkg::OP_GET_BIT: begin
				if (hit)
					acc_d = |(tgt_word_q & bit_sel);
			end
			bmr_pkg::OP_SET_BIT: begin
				wr_en   = hit;
				wr_data = val_q ? (tgt_word_q | bit_sel) : (tgt_word_q & ~bit_sel);
			end
			bmr_pkg::OP_COPY_ROW: begin
				wr_en   = 1'b1;
				wr_data = src_word_q;
			end
			bmr_pkg::OP_AND_ROW: begin
				wr_en   = 1'b1;
				wr_data = tgt_word_q & src_word_q;
			end
			bmr_pkg::OP_OR_ROW: begin
				wr_en   = 1'b1;
				wr_data = tgt_word_q | src_word_q;
			end
			bmr_pkg::OP_TEST_ONES: begin
				test_ok = ((~tgt_word_q) & test_mask) == '0;
				acc_d   = acc_q & test_ok;
			end
			bmr_pkg::OP_TEST_ZEROS: begin
				test_ok = (tgt_word_q & test_mask) == '0;
				acc_d   = acc_q & test_ok;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		// a range error leaves the store untouched
		wr_en = wr_en && cmd.apply && !err_q;
	end

	assign wr_addr = AW'(32'(tgt_q) * WORDS_PER_ROW + 32'(word_q));

	// row store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.clear)
			mem[clr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd || cmd.apply) begin
			src_word_q <= mem[rd_src_addr];
			tgt_word_q <= mem[rd_tgt_addr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.post) begin
			bit_result  <= !err_q && acc_q && (op_q inside {bmr_pkg::OP_GET_BIT,
				bmr_pkg::OP_TEST_ONES, bmr_pkg::OP_TEST_ZEROS});
			range_error <= err_q;
		end
	end

endmodule

// ----- hdl/bit_matrix_row_engine.sv -----
// ----------------------------------------------------------------------------
// bit_matrix_row_engine
// Bit matrix held as rows of words, with bit and row operations.
// ----------------------------------------------------------------------------
// Items arrive on req (valid/ready): opcode, target_row, source_row, column
// and bit_value. Each item gives exactly one result on rsp (valid/ready):
// bit_result and range_error. Operations get or set one bit, copy, AND or
// OR a source row into a target row, or test a row's used columns for all
// ones or all zeros. Out-of-range operands flag range_error, store unchanged.
// Every item walks the WORDS_PER_ROW words of its row through the store,
// one word per cycle on one write port and two read ports: after accept it
// passes READ, APPLY for each word and DONE, where its result is registered,
// and a new item is taken only after the previous one has left DONE.
// After reset the store is swept to zero with req.ready low;
// configuration writes are taken throughout. Registers: 0 active_columns,
// 1 active_rows.
// A result waits in the output register while rsp is stalled; the next
// item is still accepted and held back only when its own result is due.
// ----------------------------------------------------------------------------
module bit_matrix_row_engine #(
	parameter int MAX_ROWS      = bmr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS   = bmr_pkg::MAX_COLUMNS_DEF,
	parameter int WORD_BITS     = bmr_pkg::WORD_BITS_DEF,
	parameter int WORDS_PER_ROW = bmr_pkg::WORDS_PER_ROW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bmr_req_if.sink                       req,
	bmr_rsp_if.source                     rsp,
	input  logic                          cfg_wr_en,
	input  logic [bmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmr_pkg::CFG_W-1:0]     cfg_data
);

	bmr_pkg::ctl_cmd_t cmd;
	bmr_pkg::ctl_sts_t sts;

	bmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bmr_dp #(
		.MAX_ROWS      (MAX_ROWS),
		.MAX_COLUMNS   (MAX_COLUMNS),
		.WORD_BITS     (WORD_BITS),
		.WORDS_PER_ROW (WORDS_PER_ROW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (req.opcode),
		.target_row  (req.target_row),
		.source_row  (req.source_row),
		.column      (req.column),
		.bit_value   (req.bit_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.bit_result  (rsp.bit_result),
		.range_error (rsp.range_error)
	);

endmodule
